// ===== hdl/hbad_pkg.sv =====
package hbad_pkg;

   // Address bits that reach the cartridge ROM
   localparam int ROM_ADDR_BITS = 25;
   localparam logic [24:0] ROM_MASK = 25'((33'd1 << ROM_ADDR_BITS) - 33'd1);

   // Target codes
   localparam logic [3:0] TGT_BIOS   = 4'd0;
   localparam logic [3:0] TGT_LATCH  = 4'd1;
   localparam logic [3:0] TGT_EWRAM  = 4'd2;
   localparam logic [3:0] TGT_IWRAM  = 4'd3;
   localparam logic [3:0] TGT_IO     = 4'd4;
   localparam logic [3:0] TGT_PAL    = 4'd5;
   localparam logic [3:0] TGT_VRAM   = 4'd6;
   localparam logic [3:0] TGT_OAM    = 4'd7;
   localparam logic [3:0] TGT_ROM    = 4'd8;
   localparam logic [3:0] TGT_EEPROM = 4'd9;
   localparam logic [3:0] TGT_SAVE   = 4'd10;
   localparam logic [3:0] TGT_GPIO   = 4'd11;
   localparam logic [3:0] TGT_CONST  = 4'd12;
   localparam logic [3:0] TGT_OPEN   = 4'd13;
   localparam logic [3:0] TGT_DROP   = 4'd14;

   // Access sizes and opcodes
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;
   localparam logic       OP_READ  = 1'b0;
   localparam logic       OP_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] REG_ROM_SIZE   = 3'd0;
   localparam logic [2:0] REG_EEPROM_EN  = 3'd1;
   localparam logic [2:0] REG_FLASH_EN   = 3'd2;
   localparam logic [2:0] REG_SRAM_EN    = 3'd3;
   localparam logic [2:0] REG_GPIO_EN    = 3'd4;
   localparam logic [2:0] REG_TILT_EN    = 3'd5;
   localparam logic [2:0] REG_FLASH_LOW  = 3'd6;

   localparam int CSR_ADDR_BITS = 5;

   typedef struct packed {
      logic        opcode;
      logic [1:0]  access_size;
      logic [31:0] bus_address;
      logic [31:0] write_value;
      logic        pc_in_bios;
      logic        bitmap_mode;
      logic [11:0] tilt_x;
      logic [11:0] tilt_y;
   } req_type;

   typedef struct packed {
      logic [3:0]  target;
      logic [24:0] local_addr;
      logic [3:0]  byte_enables;
      logic [31:0] lane_data;
      logic [1:0]  read_rotate;
      logic [1:0]  replicate_count;
      logic [31:0] const_data;
      logic        latch_bios;
      logic [13:0] latch_addr;
   } rsp_type;

   typedef struct packed {
      logic [25:0] rom_size;
      logic        eeprom_enable;
      logic        flash_enable;
      logic        sram_enable;
      logic        gpio_present;
      logic        tilt_enable;
      logic [1:0]  flash_low_bits;
   } cfg_type;

endpackage

// ===== hdl/hbad_req_if.sv =====
interface hbad_req_if;
   import hbad_pkg::*;

   logic        valid;
   logic        ready;
   logic        opcode;
   logic [1:0]  access_size;
   logic [31:0] bus_address;
   logic [31:0] write_value;
   logic        pc_in_bios;
   logic        bitmap_mode;
   logic [11:0] tilt_x;
   logic [11:0] tilt_y;

   modport source (output valid, opcode, access_size, bus_address, write_value,
                   pc_in_bios, bitmap_mode, tilt_x, tilt_y, input ready);
   modport sink   (input valid, opcode, access_size, bus_address, write_value,
                   pc_in_bios, bitmap_mode, tilt_x, tilt_y, output ready);
endinterface

// ===== hdl/hbad_rsp_if.sv =====
interface hbad_rsp_if;
   import hbad_pkg::*;

   logic        valid;
   logic        ready;
   logic [3:0]  target;
   logic [24:0] local_addr;
   logic [3:0]  byte_enables;
   logic [31:0] lane_data;
   logic [1:0]  read_rotate;
   logic [1:0]  replicate_count;
   logic [31:0] const_data;
   logic        latch_bios;
   logic [13:0] latch_addr;

   modport source (output valid, target, local_addr, byte_enables, lane_data,
                   read_rotate, replicate_count, const_data, latch_bios,
                   latch_addr, input ready);
   modport sink   (input valid, target, local_addr, byte_enables, lane_data,
                   read_rotate, replicate_count, const_data, latch_bios,
                   latch_addr, output ready);
endinterface

// ===== hdl/hbad_decode.sv =====
module hbad_decode (
   input  hbad_pkg::req_type req,
   input  hbad_pkg::cfg_type cfg,
   input  logic              gpio_seen,
   output hbad_pkg::rsp_type rsp,
   output logic              gpio_set
);
   import hbad_pkg::*;

   // The VRAM's upper 32 KiB window mirrors the 32 KiB below it.
   function automatic logic [16:0] vram_fold(input logic [16:0] x);
      logic [16:0] r;
      r = x;
      if (x > 17'h17FFF) begin
         r = x - 17'h08000;
      end
      return r;
   endfunction

   logic [1:0]  sz;
   logic [31:0] a;
   logic [31:0] al;
   logic [7:0]  region;
   logic        gpio_hit;
   logic [24:0] rom_off;
   logic [31:0] eff_read;
   logic [31:0] eff_write;
   logic        tilt_ok;
   logic [16:0] vx;
   logic [15:0] half_addr;
   logic        lanes;
   logic [7:0]  vb;

   assign a         = req.bus_address;
   assign sz        = (req.access_size == 2'd3) ? SZ_WORD : req.access_size;
   assign region    = al[31:24];
   assign gpio_hit  = (al >= 32'h080000C4) && (al <= 32'h080000C8);
   assign rom_off   = al[24:0] & ROM_MASK;
   assign eff_read  = (sz == SZ_WORD) ? (a + {30'd0, cfg.flash_low_bits}) : a;
   assign eff_write = (sz == SZ_BYTE) ? a : (a + {30'd0, cfg.flash_low_bits});
   assign tilt_ok   = (sz == SZ_BYTE) && cfg.tilt_enable;
   assign vx        = {a[16:1], 1'b0};
   assign half_addr = al[16:1];
   assign vb        = req.write_value[7:0];

   always_comb begin
      unique case (sz)
         SZ_BYTE: al = a;
         SZ_HALF: al = {a[31:1], 1'b0};
         default: al = {a[31:2], 2'b00};
      endcase
   end

   always_comb begin
      rsp      = '0;
      lanes    = 1'b0;
      gpio_set = 1'b0;
      if (req.opcode == OP_READ) begin
         rsp.target = TGT_OPEN;
         unique case (sz)
            SZ_HALF: rsp.read_rotate = {1'b0, a[0]};
            SZ_WORD: rsp.read_rotate = a[1:0];
            default: rsp.read_rotate = 2'd0;
         endcase
         unique case (region)
            8'h00: begin
               if (req.pc_in_bios) begin
                  rsp.target     = TGT_BIOS;
                  rsp.local_addr = {11'd0, al[13:0]};
                  rsp.latch_bios = 1'b1;
                  rsp.latch_addr = (al[13:0] + 14'd8) & 14'h3FFC;
               end else if (al < 32'h00004000) begin
                  rsp.target     = TGT_LATCH;
                  rsp.local_addr = {23'd0, al[1:0]};
               end
            end
            8'h02: begin
               rsp.target = TGT_EWRAM; rsp.local_addr = {7'd0, al[17:0]};
            end
            8'h03: begin
               rsp.target = TGT_IWRAM; rsp.local_addr = {10'd0, al[14:0]};
            end
            8'h04: begin
               if (al < 32'h04000400) begin
                  rsp.target = TGT_IO; rsp.local_addr = {15'd0, al[9:0]};
               end
            end
            8'h05: begin
               rsp.target = TGT_PAL; rsp.local_addr = {15'd0, al[9:0]};
            end
            8'h06: begin
               rsp.target = TGT_VRAM; rsp.local_addr = {8'd0, vram_fold(al[16:0])};
            end
            8'h07: begin
               rsp.target = TGT_OAM; rsp.local_addr = {15'd0, al[9:0]};
            end
            8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C: begin
               if (sz != SZ_BYTE && cfg.gpio_present && gpio_seen && gpio_hit) begin
                  rsp.target = TGT_GPIO; rsp.local_addr = rom_off;
               end else if ({1'b0, rom_off} < cfg.rom_size) begin
                  rsp.target = TGT_ROM; rsp.local_addr = rom_off;
               end else begin
                  // Past the end of ROM the bus returns its own address pattern.
                  rsp.target = TGT_CONST;
                  unique case (sz)
                     SZ_BYTE: rsp.const_data = {24'd0, (a[0] ? a[16:9] : a[8:1])};
                     SZ_HALF: rsp.const_data = {16'd0, half_addr};
                     default: rsp.const_data = {half_addr + 16'd1, half_addr};
                  endcase
               end
            end
            8'h0D: begin
               if (cfg.eeprom_enable) begin
                  rsp.target = TGT_EEPROM;
               end else if (sz != SZ_BYTE) begin
                  rsp.target = TGT_CONST;
               end
            end
            8'h0E, 8'h0F: begin
               if (tilt_ok && a == 32'h0E008200) begin
                  rsp.target = TGT_CONST; rsp.const_data = {24'd0, req.tilt_x[7:0]};
               end else if (tilt_ok && a == 32'h0E008300) begin
                  rsp.target     = TGT_CONST;
                  rsp.const_data = {24'd0, 4'h8, req.tilt_x[11:8]};
               end else if (tilt_ok && a == 32'h0E008400) begin
                  rsp.target = TGT_CONST; rsp.const_data = {24'd0, req.tilt_y[7:0]};
               end else if (tilt_ok && a == 32'h0E008500) begin
                  rsp.target     = TGT_CONST;
                  rsp.const_data = {28'd0, req.tilt_y[11:8]};
               end else if (cfg.flash_enable || cfg.sram_enable) begin
                  rsp.target          = TGT_SAVE;
                  rsp.local_addr      = eff_read[24:0];
                  rsp.replicate_count = sz;
               end
            end
            default: rsp.target = TGT_OPEN;
         endcase
      end else begin
         rsp.target = TGT_DROP;
         unique case (region)
            8'h02: begin
               rsp.target = TGT_EWRAM; rsp.local_addr = {7'd0, al[17:0]}; lanes = 1'b1;
            end
            8'h03: begin
               rsp.target = TGT_IWRAM; rsp.local_addr = {10'd0, al[14:0]}; lanes = 1'b1;
            end
            8'h04: begin
               if (al < 32'h04000400) begin
                  rsp.target = TGT_IO; rsp.local_addr = {15'd0, al[9:0]}; lanes = 1'b1;
               end
            end
            8'h05: begin
               rsp.target = TGT_PAL;
               if (sz == SZ_BYTE) begin
                  // A byte write lands on the whole halfword, duplicated.
                  rsp.local_addr   = {15'd0, a[9:1], 1'b0};
                  rsp.byte_enables = a[1] ? 4'b1100 : 4'b0011;
                  rsp.lane_data    = a[1] ? {vb, vb, 16'd0} : {16'd0, vb, vb};
               end else begin
                  rsp.local_addr = {15'd0, al[9:0]}; lanes = 1'b1;
               end
            end
            8'h06: begin
               if (sz == SZ_BYTE) begin
                  if ((!req.bitmap_mode && vx <= 17'h0FFFF) ||
                      (req.bitmap_mode && vx <= 17'h13FFF)) begin
                     rsp.target       = TGT_VRAM;
                     rsp.local_addr   = {8'd0, vram_fold(vx)};
                     rsp.byte_enables = a[1] ? 4'b1100 : 4'b0011;
                     rsp.lane_data    = a[1] ? {vb, vb, 16'd0} : {16'd0, vb, vb};
                  end
               end else if (!req.bitmap_mode || al[16:14] != 3'b110) begin
                  rsp.target     = TGT_VRAM;
                  rsp.local_addr = {8'd0, vram_fold(al[16:0])};
                  lanes          = 1'b1;
               end
            end
            8'h07: begin
               if (sz != SZ_BYTE) begin
                  rsp.target = TGT_OAM; rsp.local_addr = {15'd0, al[9:0]}; lanes = 1'b1;
               end
            end
            8'h08: begin
               if (sz != SZ_BYTE && cfg.gpio_present && gpio_hit) begin
                  rsp.target       = TGT_GPIO;
                  rsp.local_addr   = rom_off;
                  rsp.byte_enables = 4'b0011;
                  rsp.lane_data    = {16'd0, req.write_value[15:0]};
                  gpio_set         = 1'b1;
               end
            end
            8'h0D: begin
               if (cfg.eeprom_enable) begin
                  rsp.target       = TGT_EEPROM;
                  rsp.byte_enables = 4'b0001;
                  rsp.lane_data    = {24'd0, vb};
               end
            end
            8'h0E, 8'h0F: begin
               if (!cfg.eeprom_enable || cfg.flash_enable || cfg.sram_enable) begin
                  rsp.target       = TGT_SAVE;
                  rsp.local_addr   = eff_write[24:0];
                  rsp.byte_enables = 4'b0001;
                  rsp.lane_data    = {24'd0, vb};
               end
            end
            default: rsp.target = TGT_DROP;
         endcase
         if (lanes) begin
            unique case (sz)
               SZ_BYTE: begin
                  rsp.byte_enables = 4'b0001 << a[1:0];
                  rsp.lane_data    = {24'd0, vb} << {a[1:0], 3'b000};
               end
               SZ_HALF: begin
                  rsp.byte_enables = a[1] ? 4'b1100 : 4'b0011;
                  rsp.lane_data    = a[1] ? {req.write_value[15:0], 16'd0}
                                          : {16'd0, req.write_value[15:0]};
               end
               default: begin
                  rsp.byte_enables = 4'b1111;
                  rsp.lane_data    = req.write_value;
               end
            endcase
         end
      end
   end

endmodule

// ===== hdl/handheld_bus_address_decoder.sv =====
// Bus address decoder for a handheld console memory map.
// The req_chan channel takes one CPU bus access per item: opcode, size,
// address, write data and a few core status bits. The rsp_chan channel
// returns one decoded item per access: target, local address, byte enables
// and lane data for writes, read rotation, save byte replication, made-up
// read data and the BIOS latch request.
// From acceptance to the result being shown, the access is held in an input
// register, decoded by combinational logic and caught in the result
// register. One item is accepted in every cycle while the receiver does not
// stall; the rate is set by the single decode pass between those two
// registers.
// When the receiver stalls, the result register holds and the input
// register keeps accepting until it is also full, so at most two items
// wait inside the block.
// The csr_ port is APB-style; registers lie at byte address 4*index and
// should only be written while the block is idle.
// Reset is synchronous: it empties both stages, clears the GPIO-seen flag
// and returns the registers to their defaults.
module handheld_bus_address_decoder (
   input  logic                               clock,
   input  logic                               reset,
   hbad_req_if.sink                           req_chan,
   hbad_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hbad_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import hbad_pkg::*;

   // Configuration registers
   cfg_type     cfg_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   // Input stage
   logic        in_valid_ff;
   req_type     in_ff;
   req_type     in_in;

   // Result stage
   logic        out_valid_ff;
   rsp_type     out_ff;
   rsp_type     out_in;

   // Set once a halfword or word write has reached the GPIO port.
   logic        gpio_seen_ff;
   logic        gpio_set;

   logic        req_take;
   logic        out_load;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rom_size       <= '0;
         cfg_ff.eeprom_enable  <= 1'b1;
         cfg_ff.flash_enable   <= 1'b1;
         cfg_ff.sram_enable    <= 1'b1;
         cfg_ff.gpio_present   <= 1'b0;
         cfg_ff.tilt_enable    <= 1'b0;
         cfg_ff.flash_low_bits <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ROM_SIZE:  cfg_ff.rom_size       <= csr_pwdata[25:0];
            REG_EEPROM_EN: cfg_ff.eeprom_enable  <= csr_pwdata[0];
            REG_FLASH_EN:  cfg_ff.flash_enable   <= csr_pwdata[0];
            REG_SRAM_EN:   cfg_ff.sram_enable    <= csr_pwdata[0];
            REG_GPIO_EN:   cfg_ff.gpio_present   <= csr_pwdata[0];
            REG_TILT_EN:   cfg_ff.tilt_enable    <= csr_pwdata[0];
            REG_FLASH_LOW: cfg_ff.flash_low_bits <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROM_SIZE:  csr_prdata = {6'd0, cfg_ff.rom_size};
         REG_EEPROM_EN: csr_prdata = {31'd0, cfg_ff.eeprom_enable};
         REG_FLASH_EN:  csr_prdata = {31'd0, cfg_ff.flash_enable};
         REG_SRAM_EN:   csr_prdata = {31'd0, cfg_ff.sram_enable};
         REG_GPIO_EN:   csr_prdata = {31'd0, cfg_ff.gpio_present};
         REG_TILT_EN:   csr_prdata = {31'd0, cfg_ff.tilt_enable};
         REG_FLASH_LOW: csr_prdata = {30'd0, cfg_ff.flash_low_bits};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // The result register loads whenever it is empty or being emptied; the
   // input register may refill in the same cycle that it hands its item on.
   assign out_load       = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || out_load;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_in.opcode      = req_chan.opcode;
   assign in_in.access_size = req_chan.access_size;
   assign in_in.bus_address = req_chan.bus_address;
   assign in_in.write_value = req_chan.write_value;
   assign in_in.pc_in_bios  = req_chan.pc_in_bios;
   assign in_in.bitmap_mode = req_chan.bitmap_mode;
   assign in_in.tilt_x      = req_chan.tilt_x;
   assign in_in.tilt_y      = req_chan.tilt_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (out_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
   end

   hbad_decode u_decode (
      .req       (in_ff),
      .cfg       (cfg_ff),
      .gpio_seen (gpio_seen_ff),
      .rsp       (out_in),
      .gpio_set  (gpio_set)
   );

   // The flag changes only as an item leaves the input register, so the
   // next item decoded sees the effect of all earlier ones.
   always_ff @(posedge clock) begin
      if (reset) begin
         gpio_seen_ff <= 1'b0;
      end else if (out_load && gpio_set) begin
         gpio_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.target          = out_ff.target;
   assign rsp_chan.local_addr      = out_ff.local_addr;
   assign rsp_chan.byte_enables    = out_ff.byte_enables;
   assign rsp_chan.lane_data       = out_ff.lane_data;
   assign rsp_chan.read_rotate     = out_ff.read_rotate;
   assign rsp_chan.replicate_count = out_ff.replicate_count;
   assign rsp_chan.const_data      = out_ff.const_data;
   assign rsp_chan.latch_bios      = out_ff.latch_bios;
   assign rsp_chan.latch_addr      = out_ff.latch_addr;

endmodule
